// ===== rtl/isp_pkg.sv =====
`timescale 1ns / 1ps

package isp_pkg;

   localparam int OUT_CHANNELS = 4;
   localparam int CH_W         = 2;
   localparam int FRAME_W      = 16;
   localparam int FRAME_EXT_W  = 18;
   localparam int SAMPLE_W     = 16;
   localparam int SPEED_W      = 20;
   localparam int SPEED_FRAC   = 16;
   localparam int CCNT_W       = 3;
   localparam int MODE_W       = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 20;

   localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SET_PLAY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_POS  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FRAME   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_FRAME    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic signed [SPEED_W-1:0] SPEED_RESET = 20'sd65536;
   localparam logic [CCNT_W-1:0]         CCNT_RESET  = 3'd1;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_TICK,
      OP_RESTART,
      OP_SET_PLAY,
      OP_SET_POS
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [FRAME_W-1:0]         word_address;
      logic signed [SAMPLE_W-1:0] word_value;
      logic                       play_flag;
      logic [FRAME_W-1:0]         new_position;
   } entry_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      loop_enable;
      logic [FRAME_W-1:0]        start_frame;
      logic [FRAME_W-1:0]        last_frame;
      logic [CCNT_W-1:0]         channel_count;
   } cfg_type;

endpackage

// ===== rtl/isp_if.sv =====
`timescale 1ns / 1ps

interface isp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] word_address;
   logic signed [15:0] word_value;
   logic        play_flag;
   logic [15:0] new_position;

   modport source (output valid, mode, word_address, word_value, play_flag, new_position,
                   input ready);
   modport sink (input valid, mode, word_address, word_value, play_flag, new_position,
                 output ready);
endinterface

interface isp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] ch0_sample;
   logic signed [15:0] ch1_sample;
   logic signed [15:0] ch2_sample;
   logic signed [15:0] ch3_sample;
   logic               playing;

   modport source (output valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample, playing,
                   input ready);
   modport sink (input valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample, playing,
                 output ready);
endinterface

interface isp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [19:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/isp_front.sv =====
`timescale 1ns / 1ps

module isp_front (
   input  logic               clock,
   input  logic               reset,
   isp_req_if.sink            req_chan,
   output logic               head_valid,
   output isp_pkg::entry_type head_entry,
   input  logic               head_pop
);

   localparam logic [1:0] DEPTH = 2'd2;

   isp_pkg::entry_type slot_ff [2];
   isp_pkg::entry_type dec;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       known;
   logic       push;

   // classify the incoming transaction
   always_comb begin
      dec.word_address = req_chan.word_address;
      dec.word_value   = req_chan.word_value;
      dec.play_flag    = req_chan.play_flag;
      dec.new_position = req_chan.new_position;
      known            = 1'b1;
      unique case (req_chan.mode)
         isp_pkg::MODE_LOAD:     dec.op = isp_pkg::OP_LOAD;
         isp_pkg::MODE_TICK:     dec.op = isp_pkg::OP_TICK;
         isp_pkg::MODE_RESTART:  dec.op = isp_pkg::OP_RESTART;
         isp_pkg::MODE_SET_PLAY: dec.op = isp_pkg::OP_SET_PLAY;
         isp_pkg::MODE_SET_POS:  dec.op = isp_pkg::OP_SET_POS;
         default: begin
            dec.op = isp_pkg::OP_TICK;
            known  = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (count_ff != DEPTH);
   assign push           = req_chan.valid && req_chan.ready && known;
   assign head_valid     = (count_ff != 2'd0);
   assign head_entry     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/isp_back.sv =====
`timescale 1ns / 1ps

module isp_back #(
   parameter int STORE_WORDS  = 65536,
   parameter int FRAC_BITS    = 16,
   parameter int MAX_CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  isp_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  isp_pkg::entry_type head_entry,
   output logic               head_pop,
   isp_rsp_if.source          rsp_chan
);

   localparam int ADDR_W   = $clog2(STORE_WORDS);
   localparam int POS_W    = FRAC_BITS + isp_pkg::FRAME_EXT_W;
   localparam int RAW_W    = isp_pkg::FRAME_W + isp_pkg::CH_W;
   localparam int DIFF_W   = isp_pkg::SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + FRAC_BITS + 1;
   localparam int PAD_W    = isp_pkg::FRAME_EXT_W - isp_pkg::FRAME_W;
   localparam int SH_UP    = (FRAC_BITS >= isp_pkg::SPEED_FRAC) ?
                             FRAC_BITS - isp_pkg::SPEED_FRAC : 0;
   localparam int SH_DN    = (FRAC_BITS < isp_pkg::SPEED_FRAC) ?
                             isp_pkg::SPEED_FRAC - FRAC_BITS : 0;
   localparam logic [isp_pkg::CCNT_W-1:0] MAX_CCNT = isp_pkg::CCNT_W'(MAX_CHANNELS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   logic signed [isp_pkg::SAMPLE_W-1:0] mem [STORE_WORDS];

   state_type                           state_ff, state_in;
   logic signed [POS_W-1:0]             pos_ff, pos_in;
   logic                                play_ff, play_in;
   logic [isp_pkg::FRAME_W-1:0]         cur_ff, cur_in;
   logic [isp_pkg::FRAME_W-1:0]         nxt_ff, nxt_in;
   logic [FRAC_BITS-1:0]                frac_ff, frac_in;
   logic [isp_pkg::CCNT_W-1:0]          chans_ff, chans_in;
   logic [isp_pkg::CH_W-1:0]            ch_ff, ch_in;
   logic                                adv_ff, adv_in;
   logic                                out_vld_ff, out_vld_in;
   logic                                out_play_ff, out_play_in;
   logic signed [isp_pkg::SAMPLE_W-1:0] out_samp_ff [isp_pkg::OUT_CHANNELS];

   logic                                rd_vld_ff, prod_vld_ff;
   logic [isp_pkg::CH_W-1:0]            rd_ch_ff, prod_ch_ff;
   logic signed [isp_pkg::SAMPLE_W-1:0] rd_a_ff, rd_b_ff, base_ff;
   logic signed [PROD_W-1:0]            prod_ff;
   logic signed [isp_pkg::SAMPLE_W-1:0] samp_ff [isp_pkg::OUT_CHANNELS];

   logic signed [isp_pkg::FRAME_EXT_W-1:0] frame_now, start_ext, last_ext, pre_frame;
   logic signed [POS_W-1:0]             start_pos, last_pos, set_pos, pre_pos, spd;
   logic signed [POS_W-1:0]             spd_ext;
   logic                                above, below, pre_ok;
   logic [isp_pkg::FRAME_W-1:0]         pre_cur, pre_nxt;
   logic [isp_pkg::CCNT_W-1:0]          chans;
   logic                                ch_last;
   logic [RAW_W-1:0]                    raw_a, raw_b;
   logic [ADDR_W-1:0]                   addr_a, addr_b, wr_addr;
   logic                                mem_we;
   logic                                tick_start;
   logic                                load_out;
   logic signed [DIFF_W-1:0]            diff;
   logic signed [FRAC_BITS:0]           frac_s;
   logic signed [PROD_W-1:0]            shifted, total;

   // region check, shared by the check before reading and the one after advancing
   assign frame_now = pos_ff[POS_W-1:FRAC_BITS];
   assign start_ext = {{PAD_W{1'b0}}, cfg.start_frame};
   assign last_ext  = {{PAD_W{1'b0}}, cfg.last_frame};
   assign start_pos = {start_ext, {FRAC_BITS{1'b0}}};
   assign last_pos  = {last_ext, {FRAC_BITS{1'b0}}};
   assign set_pos   = {{PAD_W{1'b0}}, head_entry.new_position, {FRAC_BITS{1'b0}}};
   assign above     = frame_now > last_ext;
   assign below     = frame_now < start_ext;
   assign pre_ok    = !(above || below) || cfg.loop_enable;

   always_comb begin
      priority if (above) begin
         pre_pos = start_pos;
      end else if (below) begin
         pre_pos = last_pos;
      end else begin
         pre_pos = pos_ff;
      end
   end

   assign pre_frame = pre_pos[POS_W-1:FRAC_BITS];
   assign pre_cur   = pre_frame[isp_pkg::FRAME_W-1:0];

   always_comb begin
      priority if (pre_frame < last_ext) begin
         pre_nxt = pre_cur + 16'd1;
      end else if (cfg.loop_enable) begin
         pre_nxt = cfg.start_frame;
      end else begin
         pre_nxt = pre_cur;
      end
   end

   always_comb begin
      priority if (cfg.channel_count == '0) begin
         chans = isp_pkg::CCNT_W'(1);
      end else if (cfg.channel_count > MAX_CCNT) begin
         chans = MAX_CCNT;
      end else begin
         chans = cfg.channel_count;
      end
   end

   assign spd_ext = POS_W'(cfg.speed);
   assign spd     = (FRAC_BITS >= isp_pkg::SPEED_FRAC) ? (spd_ext <<< SH_UP)
                                                       : (spd_ext >>> SH_DN);

   // store addresses for the channel in flight
   assign raw_a   = RAW_W'(cur_ff) * RAW_W'(chans_ff) + RAW_W'(ch_ff);
   assign raw_b   = RAW_W'(nxt_ff) * RAW_W'(chans_ff) + RAW_W'(ch_ff);
   assign addr_a  = ADDR_W'(raw_a);
   assign addr_b  = ADDR_W'(raw_b);
   assign wr_addr = ADDR_W'(head_entry.word_address);
   assign ch_last = (isp_pkg::CCNT_W'(ch_ff) == chans_ff - isp_pkg::CCNT_W'(1));

   assign head_pop   = (state_ff == S_IDLE) && head_valid;
   assign mem_we     = head_pop && (head_entry.op == isp_pkg::OP_LOAD);
   assign tick_start = head_pop && (head_entry.op == isp_pkg::OP_TICK);
   assign load_out   = (state_ff == S_DONE) && (!out_vld_ff || rsp_chan.ready);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      play_in     = play_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      frac_in     = frac_ff;
      chans_in    = chans_ff;
      ch_in       = ch_ff;
      adv_in      = adv_ff;
      out_vld_in  = out_vld_ff && !rsp_chan.ready;
      out_play_in = out_play_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               unique case (head_entry.op)
                  isp_pkg::OP_LOAD: begin
                  end
                  isp_pkg::OP_RESTART: begin
                     pos_in  = start_pos;
                     play_in = 1'b1;
                  end
                  isp_pkg::OP_SET_PLAY: begin
                     play_in = head_entry.play_flag;
                  end
                  isp_pkg::OP_SET_POS: begin
                     pos_in = set_pos;
                  end
                  isp_pkg::OP_TICK: begin
                     if (play_ff && pre_ok) begin
                        pos_in   = pre_pos;
                        cur_in   = pre_cur;
                        nxt_in   = pre_nxt;
                        frac_in  = pre_pos[FRAC_BITS-1:0];
                        chans_in = chans;
                        ch_in    = '0;
                        adv_in   = 1'b1;
                        state_in = S_READ;
                     end else begin
                        play_in  = 1'b0;
                        adv_in   = 1'b0;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (ch_ff == '0) begin
               pos_in = pos_ff + spd;
            end
            ch_in = ch_ff + isp_pkg::CH_W'(1);
            if (ch_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               out_vld_in  = 1'b1;
               out_play_in = adv_ff && pre_ok;
               if (adv_ff) begin
                  play_in = pre_ok;
                  if (pre_ok) begin
                     pos_in = pre_pos;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pos_ff      <= '0;
         play_ff     <= 1'b0;
         out_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         play_ff     <= play_in;
         out_vld_ff  <= out_vld_in;
         rd_vld_ff   <= (state_ff == S_READ);
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      frac_ff     <= frac_in;
      chans_ff    <= chans_in;
      ch_ff       <= ch_in;
      adv_ff      <= adv_in;
      out_play_ff <= out_play_in;
   end

   // sample store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= head_entry.word_value;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // interpolation pipeline
   assign diff    = DIFF_W'(rd_b_ff) - DIFF_W'(rd_a_ff);
   assign frac_s  = {1'b0, frac_ff};
   assign shifted = prod_ff >>> FRAC_BITS;
   assign total   = shifted + PROD_W'(base_ff);

   always_ff @(posedge clock) begin
      rd_ch_ff   <= ch_ff;
      prod_ch_ff <= rd_ch_ff;
      prod_ff    <= diff * frac_s;
      base_ff    <= rd_a_ff;
   end

   always_ff @(posedge clock) begin
      if (tick_start) begin
         for (int i = 0; i < isp_pkg::OUT_CHANNELS; i++) begin
            samp_ff[i] <= '0;
         end
      end else if (prod_vld_ff) begin
         samp_ff[prod_ch_ff] <= total[isp_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int i = 0; i < isp_pkg::OUT_CHANNELS; i++) begin
            out_samp_ff[i] <= samp_ff[i];
         end
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.ch0_sample = out_samp_ff[0];
   assign rsp_chan.ch1_sample = out_samp_ff[1];
   assign rsp_chan.ch2_sample = out_samp_ff[2];
   assign rsp_chan.ch3_sample = out_samp_ff[3];
   assign rsp_chan.playing    = out_play_ff;

endmodule

// ===== rtl/interpolating_sample_player.sv =====
`timescale 1ns / 1ps

// interpolating sample player
// req_chan carries one command transaction: load a store word, tick, restart,
// set play or set position. a tick returns one rsp_chan transaction with four
// interpolated channel samples and the playing flag; other commands return none.
// csr_chan writes speed, loop enable, start frame, last frame and channel count;
// write it only while no command is outstanding.
// commands enter a two-entry queue and the execution side works through them in
// order. a tick that plays reads the store, which has two read ports, so one
// channel (current and next frame word) is read per cycle; then the multiply and
// add stages drain and the result is registered. a tick that does not play skips
// the store reads and returns zero samples.
// reset clears the position to zero, stops playback and loads the register
// defaults; store contents are undefined until loaded.
// when rsp_chan stalls the result waits in its output register, the queue keeps
// taking commands until full, and req_chan.ready drops.
module interpolating_sample_player #(
   parameter int STORE_WORDS  = 65536,
   parameter int FRAC_BITS    = 16,
   parameter int MAX_CHANNELS = 4
) (
   input logic         clock,
   input logic         reset,
   isp_req_if.sink     req_chan,
   isp_rsp_if.source   rsp_chan,
   isp_csr_if.sink     csr_chan
);

   isp_pkg::cfg_type   cfg_ff, cfg_in;
   logic               head_valid;
   logic               head_pop;
   isp_pkg::entry_type head_entry;
   logic               csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_chan.index)
            isp_pkg::CSR_SPEED:
               cfg_in.speed = csr_chan.data[isp_pkg::SPEED_W-1:0];
            isp_pkg::CSR_LOOP_ENABLE:
               cfg_in.loop_enable = csr_chan.data[0];
            isp_pkg::CSR_START_FRAME:
               cfg_in.start_frame = csr_chan.data[isp_pkg::FRAME_W-1:0];
            isp_pkg::CSR_LAST_FRAME:
               cfg_in.last_frame = csr_chan.data[isp_pkg::FRAME_W-1:0];
            isp_pkg::CSR_CHANNEL_COUNT:
               cfg_in.channel_count = csr_chan.data[isp_pkg::CCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed         <= isp_pkg::SPEED_RESET;
         cfg_ff.loop_enable   <= 1'b0;
         cfg_ff.start_frame   <= '0;
         cfg_ff.last_frame    <= '0;
         cfg_ff.channel_count <= isp_pkg::CCNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   isp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   isp_back #(
      .STORE_WORDS  (STORE_WORDS),
      .FRAC_BITS    (FRAC_BITS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== test/tb_interpolating_sample_player.sv =====
`timescale 1ns / 1ps

module tb_interpolating_sample_player;

   localparam int STORE_WORDS   = 65536;
   localparam int FRAC          = 16;
   localparam int SETTLE_CYCLES = 32;
   localparam int DRAIN_LIMIT   = 200000;
   localparam logic [isp_pkg::MODE_W-1:0] MODE_TOP = '1;

   typedef struct {
      longint pos;
      bit     on;
   } player_type;

   typedef struct packed {
      logic [isp_pkg::OUT_CHANNELS-1:0][isp_pkg::SAMPLE_W-1:0] ch;
      logic                                                    playing;
   } tick_frame_type;

   logic clock;
   logic reset;

   isp_req_if req_chan ();
   isp_rsp_if rsp_chan ();
   isp_csr_if csr_chan ();

   interpolating_sample_player dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [isp_pkg::SAMPLE_W-1:0] sample_mem [STORE_WORDS];
   bit                           word_loaded [STORE_WORDS];
   player_type                   player;
   isp_pkg::cfg_type             cfg_now;
   tick_frame_type               expected_frames [$];
   int unsigned                  tick_reads [$];
   int                           error_count;
   int                           issued_count;
   int                           send_idle_pct;
   int                           stall_pct;
   int                           stall_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_len();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
   endfunction

   // region rule in frame units, returns 0 when playback stops
   function automatic bit region_hold(inout longint pos);
      longint frame;
      frame = pos >>> FRAC;
      if (frame > longint'(cfg_now.last_frame)) begin
         if (!cfg_now.loop_enable) return 1'b0;
         pos = longint'(cfg_now.start_frame) << FRAC;
      end else if (frame < longint'(cfg_now.start_frame)) begin
         if (!cfg_now.loop_enable) return 1'b0;
         pos = longint'(cfg_now.last_frame) << FRAC;
      end
      return 1'b1;
   endfunction

   function automatic int effective_channels();
      if (cfg_now.channel_count == 0) return 1;
      if (cfg_now.channel_count > isp_pkg::OUT_CHANNELS) return isp_pkg::OUT_CHANNELS;
      return int'(cfg_now.channel_count);
   endfunction

   function automatic tick_frame_type advance_tick(inout player_type st);
      tick_frame_type res;
      longint         chans, cur, nxt, frac, a, b, v;
      int unsigned    addr_a, addr_b;
      int             i;
      res = '0;
      if (st.on && !region_hold(st.pos)) st.on = 1'b0;
      if (st.on) begin
         chans = longint'(effective_channels());
         cur   = st.pos >>> FRAC;
         frac  = st.pos & ((longint'(1) << FRAC) - 1);
         if (cur < longint'(cfg_now.last_frame)) nxt = cur + 1;
         else nxt = cfg_now.loop_enable ? longint'(cfg_now.start_frame) : cur;
         for (i = 0; i < chans; i++) begin
            addr_a = 32'((cur * chans + i) % STORE_WORDS);
            addr_b = 32'((nxt * chans + i) % STORE_WORDS);
            tick_reads.push_back(addr_a);
            tick_reads.push_back(addr_b);
            a = longint'($signed(sample_mem[addr_a]));
            b = longint'($signed(sample_mem[addr_b]));
            v = a + (((b - a) * frac) >>> FRAC);
            res.ch[i] = v[isp_pkg::SAMPLE_W-1:0];
         end
         st.pos += longint'(cfg_now.speed);
         if (!region_hold(st.pos)) st.on = 1'b0;
      end
      res.playing = st.on;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, $signed(want), $signed(got));
         error_count++;
      end
   endfunction

   function automatic isp_pkg::cfg_type make_cfg(
         input logic signed [isp_pkg::SPEED_W-1:0] speed,
         input logic loop_on,
         input logic [isp_pkg::FRAME_W-1:0] first,
         input logic [isp_pkg::FRAME_W-1:0] last,
         input logic [isp_pkg::CCNT_W-1:0] chans);
      isp_pkg::cfg_type c;
      c.speed         = speed;
      c.loop_enable   = loop_on;
      c.start_frame   = first;
      c.last_frame    = last;
      c.channel_count = chans;
      return c;
   endfunction

   function automatic isp_pkg::cfg_type random_cfg();
      isp_pkg::cfg_type c;
      int               s, span;
      case ($urandom_range(9))
         0: c.speed = 20'sh7FFFF;
         1: c.speed = 20'sh80000;
         2, 3: c.speed = isp_pkg::SPEED_W'($urandom);
         4: c.speed = $urandom_range(1) ? 20'sh10000 : -20'sh10000;
         default: begin
            c.speed = isp_pkg::SPEED_W'($urandom_range(32'h30000));
            if ($urandom_range(1)) c.speed = -c.speed;
         end
      endcase
      c.loop_enable = 1'($urandom_range(1));
      case ($urandom_range(19))
         0: begin
            c.start_frame = '0;
            c.last_frame  = 16'hFFFF;
         end
         1, 2: begin
            s = $urandom_range(32'hFFFF, 6);
            c.start_frame = 16'(s);
            c.last_frame  = 16'(s - int'($urandom_range(5, 1)));
         end
         3: begin
            c.last_frame  = 16'hFFFF;
            c.start_frame = 16'(32'hFFFF - $urandom_range(8));
         end
         4: begin
            c.start_frame = '0;
            c.last_frame  = 16'($urandom_range(8));
         end
         default: begin
            s    = $urandom_range(32'hFFFF);
            span = $urandom_range(12);
            c.start_frame = 16'(s);
            c.last_frame  = (s + span > 32'hFFFF) ? 16'hFFFF : 16'(s + span);
         end
      endcase
      c.channel_count = ($urandom_range(4) == 0) ? isp_pkg::CCNT_W'($urandom_range(7))
                                                 : isp_pkg::CCNT_W'($urandom_range(4, 1));
      return c;
   endfunction

   task automatic issue(input logic [isp_pkg::MODE_W-1:0] mode, input logic [15:0] addr,
                        input logic [15:0] value, input logic flag, input logic [15:0] frame);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? pick_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode;
      req_chan.word_address <= addr;
      req_chan.word_value   <= value;
      req_chan.play_flag    <= flag;
      req_chan.new_position <= frame;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (mode)
         isp_pkg::MODE_LOAD: begin
            sample_mem[addr]  = value;
            word_loaded[addr] = 1'b1;
         end
         isp_pkg::MODE_TICK: expected_frames.push_back(advance_tick(player));
         isp_pkg::MODE_RESTART: begin
            player.pos = longint'(cfg_now.start_frame) << FRAC;
            player.on  = 1'b1;
         end
         isp_pkg::MODE_SET_PLAY: player.on = flag;
         isp_pkg::MODE_SET_POS: player.pos = longint'(frame) << FRAC;
         default: ;
      endcase
      issued_count++;
   endtask

   task automatic load_word(input logic [15:0] addr, input logic [15:0] value);
      issue(isp_pkg::MODE_LOAD, addr, value, 1'($urandom), 16'($urandom));
   endtask

   // loads any store word this tick would read before it was ever written
   task automatic tick();
      player_type scratch;
      scratch = player;
      tick_reads.delete();
      void'(advance_tick(scratch));
      foreach (tick_reads[k]) begin
         if (!word_loaded[tick_reads[k]]) load_word(16'(tick_reads[k]), 16'($urandom));
      end
      issue(isp_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
   endtask

   task automatic restart_play();
      issue(isp_pkg::MODE_RESTART, 16'($urandom), 16'($urandom), 1'($urandom),
            16'($urandom));
   endtask

   task automatic set_play(input logic flag);
      issue(isp_pkg::MODE_SET_PLAY, 16'($urandom), 16'($urandom), flag, 16'($urandom));
   endtask

   task automatic set_position(input logic [15:0] frame);
      issue(isp_pkg::MODE_SET_POS, 16'($urandom), 16'($urandom), 1'($urandom), frame);
   endtask

   task automatic send_unknown(input logic [isp_pkg::MODE_W-1:0] mode);
      issue(mode, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (expected_frames.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input isp_pkg::cfg_type c);
      logic [isp_pkg::CSR_INDEX_W-1:0] idx;
      logic [isp_pkg::CSR_DATA_W-1:0]  data;
      int                              r;
      wait_drained();
      for (r = int'(isp_pkg::CSR_SPEED); r <= int'(isp_pkg::CSR_CHANNEL_COUNT); r++) begin
         idx = isp_pkg::CSR_INDEX_W'(r);
         case (idx)
            isp_pkg::CSR_SPEED:       data = c.speed;
            isp_pkg::CSR_LOOP_ENABLE: data = isp_pkg::CSR_DATA_W'(c.loop_enable);
            isp_pkg::CSR_START_FRAME: data = isp_pkg::CSR_DATA_W'(c.start_frame);
            isp_pkg::CSR_LAST_FRAME:  data = isp_pkg::CSR_DATA_W'(c.last_frame);
            default:                  data = isp_pkg::CSR_DATA_W'(c.channel_count);
         endcase
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx;
         csr_chan.data  <= data;
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
         case (idx)
            isp_pkg::CSR_SPEED:         cfg_now.speed         = data;
            isp_pkg::CSR_LOOP_ENABLE:   cfg_now.loop_enable   = data[0];
            isp_pkg::CSR_START_FRAME:   cfg_now.start_frame   = data[isp_pkg::FRAME_W-1:0];
            isp_pkg::CSR_LAST_FRAME:    cfg_now.last_frame    = data[isp_pkg::FRAME_W-1:0];
            isp_pkg::CSR_CHANNEL_COUNT: cfg_now.channel_count = data[isp_pkg::CCNT_W-1:0];
            default: ;
         endcase
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_load();
      int f, chans;
      chans = effective_channels();
      if ($urandom_range(1)) begin
         f = int'($urandom_range(32'(cfg_now.last_frame), 32'(cfg_now.start_frame)));
         load_word(16'((f * chans + int'($urandom_range(chans - 1))) % STORE_WORDS),
                   16'($urandom));
      end else begin
         load_word(16'($urandom), 16'($urandom));
      end
   endtask

   function automatic logic [15:0] random_frame();
      int lo, hi;
      if ($urandom_range(9) < 3) return 16'($urandom);
      lo = (cfg_now.start_frame > 0) ? int'(cfg_now.start_frame) - 1 : 0;
      hi = (cfg_now.last_frame < 16'hFFFF) ? int'(cfg_now.last_frame) + 1 : 32'hFFFF;
      return 16'($urandom_range(hi, lo));
   endfunction

   always @(posedge clock) begin : result_check
      tick_frame_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: result with no expectation, actual %0d %0d %0d %0d playing %0b",
                        $time, rsp_chan.ch0_sample, rsp_chan.ch1_sample,
                        rsp_chan.ch2_sample, rsp_chan.ch3_sample, rsp_chan.playing);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("ch0_sample", want.ch[0], rsp_chan.ch0_sample);
               check_field("ch1_sample", want.ch[1], rsp_chan.ch1_sample);
               check_field("ch2_sample", want.ch[2], rsp_chan.ch2_sample);
               check_field("ch3_sample", want.ch[3], rsp_chan.ch3_sample);
               check_field("playing", 16'(want.playing), 16'(rsp_chan.playing));
            end
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(99) < stall_pct) stall_left = pick_len();
         end
      end
   end

   task automatic test_idle_after_reset();
      tick();
      set_play(1'b1);
      tick();
   endtask

   task automatic test_interpolation_extremes();
      write_config(make_cfg(20'sh04000, 1'b1, 16'd10, 16'd11, 3'd2));
      load_word(16'd20, 16'h8000);
      load_word(16'd21, 16'h7FFF);
      load_word(16'd22, 16'h7FFF);
      load_word(16'd23, 16'h8000);
      restart_play();
      repeat (9) tick();
   endtask

   task automatic test_region_ends();
      int m;
      write_config(make_cfg(20'sh80000, 1'b0, 16'd0, 16'hFFFF, 3'd7));
      load_word(16'hFFFF, 16'h7FFF);
      load_word(16'hFFFC, 16'h8000);
      set_position(16'hFFFF);
      set_play(1'b1);
      tick();
      tick();
      set_position(16'd3);
      tick();
      for (m = int'(isp_pkg::MODE_SET_POS) + 1; m <= int'(MODE_TOP); m++) begin
         send_unknown(isp_pkg::MODE_W'(m));
      end
      tick();
      set_play(1'b0);
   endtask

   task automatic test_empty_region();
      write_config(make_cfg(20'sh7FFFF, 1'b1, 16'hFFFF, 16'd2, 3'd0));
      restart_play();
      tick();
      set_position(16'd0);
      tick();
   endtask

   task automatic test_random_phases(input int target);
      int first, steps, pick;
      first = issued_count;
      while (issued_count - first < target) begin
         write_config(random_cfg());
         send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
         stall_pct     = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
         restart_play();
         steps = $urandom_range(80, 30);
         repeat (steps) begin
            if (issued_count - first >= target) break;
            pick = $urandom_range(99);
            if (pick < 55) tick();
            else if (pick < 65) random_load();
            else if (pick < 72) restart_play();
            else if (pick < 80) set_play($urandom_range(3) != 0);
            else if (pick < 92) set_position(random_frame());
            else if (pick < 94) begin
               send_unknown(isp_pkg::MODE_W'($urandom_range(int'(MODE_TOP),
                                                            int'(isp_pkg::MODE_SET_POS) + 1)));
            end
            else if (pick < 95) wait_drained();
            else tick();
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= isp_pkg::MODE_LOAD;
      req_chan.word_address <= '0;
      req_chan.word_value   <= '0;
      req_chan.play_flag    <= 1'b0;
      req_chan.new_position <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= isp_pkg::CSR_SPEED;
      csr_chan.data         <= '0;
      send_idle_pct = 20;
      stall_pct     = 20;
      player.pos    = 0;
      player.on     = 1'b0;
      cfg_now = make_cfg(isp_pkg::SPEED_RESET, 1'b0, '0, '0, isp_pkg::CCNT_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_after_reset();
      test_interpolation_extremes();
      test_region_ends();
      test_empty_region();
      test_random_phases(1150 - issued_count);
      wait_drained();
      if (expected_frames.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_frames.size());
         error_count++;
      end
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
